// ===== src/gn2d_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types of the two-dimensional gradient noise evaluator.
package gn2d_pkg;

  localparam int GRID_ROWS_DEF = 64;
  localparam int GRID_COLS_DEF = 64;

  // Register stages from the input transfer to the lattice store access.
  localparam int NORM_LAT = 19;
  // Register stages of the cell divider, counted from its input register.
  localparam int POS_LAT = 9;

  localparam int GRAD_W  = 15;
  localparam int ENTRY_W = 2 * GRAD_W;
  localparam int NOISE_W = 24;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EVAL_RANGE = 2'd1,
    ST_LOAD_RANGE = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    REG_CELL_SIZE = 1'b0,
    REG_GAIN      = 1'b1
  } cfg_reg_t;

endpackage

// ===== src/gn2d_norm.sv =====
`timescale 1ns / 1ps
// Gradient normaliser: pipelined square root and division to unit length in Q1.14.
module gn2d_norm import gn2d_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [15:0]        grad_x,
  input  logic signed [15:0]        grad_y,
  output logic [ENTRY_W-1:0]        entry
);

  localparam int SQ_STAGES = 10;
  localparam int SQ_PER    = 3;
  localparam int DV_STAGES = 5;
  localparam int DV_PER    = 3;

  typedef struct packed {
    logic [31:0] s;
    logic        nx;
    logic        ny;
    logic [15:0] mx;
    logic [15:0] my;
  } side_t;

  typedef struct packed {
    logic [29:0] len;
    logic [29:0] rx;
    logic [29:0] ry;
    logic [14:0] lx;
    logic [14:0] ly;
    logic [14:0] qx;
    logic [14:0] qy;
    logic        nx;
    logic        ny;
    logic        zero;
  } div_t;

  function automatic logic [61:0] sq_step(logic [31:0] rem, logic [29:0] root,
                                          logic [1:0] pair);
    logic [33:0] r2;
    logic [33:0] trial;
    r2    = {rem, pair};
    trial = {2'b00, root, 2'b01};
    if (r2 >= trial) begin
      return {32'(r2 - trial), root[28:0], 1'b1};
    end else begin
      return {r2[31:0], root[28:0], 1'b0};
    end
  endfunction

  function automatic logic [44:0] div_step(logic [29:0] rem, logic [14:0] q, logic b,
                                           logic [29:0] len);
    logic [30:0] r2;
    r2 = {rem, b};
    if (r2 >= {1'b0, len}) begin
      return {30'(r2 - {1'b0, len}), q[13:0], 1'b1};
    end else begin
      return {r2[29:0], q[13:0], 1'b0};
    end
  endfunction

  function automatic logic [14:0] clamp_q(logic [14:0] q, logic neg, logic zero);
    if (zero) begin
      return '0;
    end else if (neg) begin
      return (q > 15'd16384) ? 15'h4000 : 15'(15'd0 - q);
    end else begin
      return (q > 15'd16383) ? 15'h3FFF : q;
    end
  endfunction

  logic signed [31:0] px;
  logic signed [31:0] py;
  logic [30:0]        x2;
  logic [30:0]        y2;
  logic               nx1;
  logic               ny1;
  logic [15:0]        mx1;
  logic [15:0]        my1;
  side_t              s2;

  logic [31:0] sq_rem  [SQ_STAGES];
  logic [29:0] sq_root [SQ_STAGES];
  side_t       sq_side [SQ_STAGES];
  logic [31:0] rem_next  [SQ_STAGES];
  logic [29:0] root_next [SQ_STAGES];

  div_t        dp;
  div_t        dv      [DV_STAGES];
  div_t        dv_next [DV_STAGES];
  logic [43:0] num_x;
  logic [43:0] num_y;

  assign px = grad_x * grad_x;
  assign py = grad_y * grad_y;

  // Digit-by-digit square root of s * 2^28, one result bit per pair of radicand bits.
  always_comb begin
    logic [31:0] rem_v;
    logic [29:0] root_v;
    logic [59:0] nv;
    for (int k = 0; k < SQ_STAGES; k++) begin
      rem_v  = (k == 0) ? 32'd0 : sq_rem[(k > 0) ? k - 1 : 0];
      root_v = (k == 0) ? 30'd0 : sq_root[(k > 0) ? k - 1 : 0];
      nv     = {((k == 0) ? s2.s : sq_side[(k > 0) ? k - 1 : 0].s), 28'd0};
      for (int i = 0; i < SQ_PER; i++) begin
        {rem_v, root_v} = sq_step(rem_v, root_v, nv[59 - 2 * (SQ_PER * k + i) -: 2]);
      end
      rem_next[k]  = rem_v;
      root_next[k] = root_v;
    end
  end

  assign num_x = {sq_side[SQ_STAGES-1].mx, 28'd0} + 44'(sq_root[SQ_STAGES-1] >> 1);
  assign num_y = {sq_side[SQ_STAGES-1].my, 28'd0} + 44'(sq_root[SQ_STAGES-1] >> 1);

  // Restoring division; the quotient never exceeds 15 bits, so the top of the
  // numerator already sits below the divisor.
  always_comb begin
    div_t d;
    for (int k = 0; k < DV_STAGES; k++) begin
      d = (k == 0) ? dp : dv[(k > 0) ? k - 1 : 0];
      for (int i = 0; i < DV_PER; i++) begin
        {d.rx, d.qx} = div_step(d.rx, d.qx, d.lx[14 - (DV_PER * k + i)], d.len);
        {d.ry, d.qy} = div_step(d.ry, d.qy, d.ly[14 - (DV_PER * k + i)], d.len);
      end
      dv_next[k] = d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2  <= px[30:0];
      y2  <= py[30:0];
      nx1 <= grad_x[15];
      ny1 <= grad_y[15];
      mx1 <= grad_x[15] ? 16'(16'd0 - grad_x) : grad_x;
      my1 <= grad_y[15] ? 16'(16'd0 - grad_y) : grad_y;

      s2.s  <= 32'(x2) + 32'(y2);
      s2.nx <= nx1;
      s2.ny <= ny1;
      s2.mx <= mx1;
      s2.my <= my1;

      for (int k = 0; k < SQ_STAGES; k++) begin
        sq_rem[k]  <= rem_next[k];
        sq_root[k] <= root_next[k];
        sq_side[k] <= (k == 0) ? s2 : sq_side[(k > 0) ? k - 1 : 0];
      end

      dp.len  <= sq_root[SQ_STAGES-1];
      dp.rx   <= 30'(num_x[43:15]);
      dp.ry   <= 30'(num_y[43:15]);
      dp.lx   <= num_x[14:0];
      dp.ly   <= num_y[14:0];
      dp.qx   <= '0;
      dp.qy   <= '0;
      dp.nx   <= sq_side[SQ_STAGES-1].nx;
      dp.ny   <= sq_side[SQ_STAGES-1].ny;
      dp.zero <= (sq_side[SQ_STAGES-1].s == 32'd0);

      for (int k = 0; k < DV_STAGES; k++) begin
        dv[k] <= dv_next[k];
      end

      entry <= {clamp_q(dv[DV_STAGES-1].qy, dv[DV_STAGES-1].ny, dv[DV_STAGES-1].zero),
                clamp_q(dv[DV_STAGES-1].qx, dv[DV_STAGES-1].nx, dv[DV_STAGES-1].zero)};
    end
  end

endmodule

// ===== src/gn2d_celldiv.sv =====
`timescale 1ns / 1ps
// Cell divider: lattice index and Q0.16 fraction of one pixel coordinate.
module gn2d_celldiv import gn2d_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [7:0]  coord,
  input  logic [7:0]  divisor,
  output logic [7:0]  quot,
  output logic [15:0] frac
);

  localparam int STAGES = 8;
  localparam int PER    = 3;

  typedef struct packed {
    logic [7:0]  p;
    logic [7:0]  rem;
    logic [23:0] q;
  } cd_t;

  logic [7:0] p_in;
  cd_t        st      [STAGES];
  cd_t        st_next [STAGES];

  // The fraction is the same long division carried on for sixteen more bits.
  always_comb begin
    cd_t         d;
    logic [23:0] dividend;
    logic [8:0]  r2;
    for (int k = 0; k < STAGES; k++) begin
      d        = (k == 0) ? cd_t'{p: p_in, rem: 8'd0, q: 24'd0} : st[(k > 0) ? k - 1 : 0];
      dividend = {d.p, 16'd0};
      for (int i = 0; i < PER; i++) begin
        r2 = {d.rem, dividend[23 - (PER * k + i)]};
        if (r2 >= {1'b0, divisor}) begin
          d.rem = 8'(r2 - {1'b0, divisor});
          d.q   = {d.q[22:0], 1'b1};
        end else begin
          d.rem = r2[7:0];
          d.q   = {d.q[22:0], 1'b0};
        end
      end
      st_next[k] = d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_in <= coord;
      for (int k = 0; k < STAGES; k++) begin
        st[k] <= st_next[k];
      end
    end
  end

  assign quot = st[STAGES-1].q[23:16];
  assign frac = st[STAGES-1].q[15:0];

endmodule

// ===== src/gradient_noise_2d_evaluator_top.sv =====
`timescale 1ns / 1ps
// Top level of the two-dimensional gradient noise evaluator.
// One item is taken every cycle while the output is not stalled.
// The rate is set by the lattice store: four banks split by row and column parity give the
// four corners in one read, and loads write at the same stage, so no interlock is needed.
// The whole pipeline stalls only while a finished result waits at the output register.
// Reset clears the valid bits and sets the configuration registers to their defaults; the lattice store is not cleared.
module gradient_noise_2d_evaluator_top import gn2d_pkg::*; #(
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int GRID_COLS = GRID_COLS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [47:0]        s_tdata,   // row[7:0], col[15:8], grad_x[31:16], grad_y[47:32]
  input  logic [0:0]         s_tuser,   // opcode[0]
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [NOISE_W-1:0] m_tdata,   // noise_value[23:0]
  output logic [1:0]         m_tuser,   // status[1:0]
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int HALF_ROWS  = (GRID_ROWS + 1) / 2;
  localparam int HALF_COLS  = (GRID_COLS + 1) / 2;
  localparam int BANK_DEPTH = HALF_ROWS * HALF_COLS;
  localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int PAD        = NORM_LAT - 1 - POS_LAT;

  typedef struct packed {
    logic    valid;
    status_t status;
    logic    zero;
  } meta_t;

  function automatic logic [BA_W-1:0] bank_addr(logic [7:0] r, logic [7:0] c);
    logic [15:0] a;
    a = 16'(r[7:1]) * 16'(HALF_COLS) + 16'(c[7:1]);
    return a[BA_W-1:0];
  endfunction

  logic [7:0]  cell_size;
  logic [15:0] gain;
  logic [7:0]  divisor;
  logic        en;

  logic        dl_valid [NORM_LAT];
  logic        dl_op    [NORM_LAT];
  logic [7:0]  dl_row   [NORM_LAT];
  logic [7:0]  dl_col   [NORM_LAT];

  logic [ENTRY_W-1:0] norm_entry;
  logic [7:0]         y0;
  logic [7:0]         x0;
  logic [15:0]        fy;
  logic [15:0]        fx;

  logic        w_valid;
  logic        w_op;
  logic [7:0]  w_row;
  logic [7:0]  w_col;
  logic        load_err;
  logic        eval_err;
  status_t     w_status;
  logic [3:0]  bank_we;
  logic [BA_W-1:0] waddr;
  logic [BA_W-1:0] raddr [4];
  logic [ENTRY_W-1:0] rd [4];

  meta_t       meta [8];
  logic [15:0] e1_fx;
  logic [15:0] e1_fy;
  logic        e1_px;
  logic        e1_py;
  logic [31:0] e1_f2x;
  logic [31:0] e1_f2y;

  logic signed [31:0] pgx_next [4];
  logic signed [31:0] pgy_next [4];
  logic signed [31:0] e2_pgx [4];
  logic signed [31:0] e2_pgy [4];
  logic        e2_px;
  logic        e2_py;
  logic [31:0] e2_f2x;
  logic [31:0] e2_f2y;
  logic [47:0] e2_f3x;
  logic [47:0] e2_f3y;

  logic signed [32:0] zb [4];
  logic [49:0]        tx;
  logic [49:0]        ty;
  logic signed [32:0] e3_z00;
  logic signed [32:0] e3_z01;
  logic signed [32:0] e3_z10;
  logic signed [32:0] e3_z11;
  logic [16:0]        e3_sx;
  logic [16:0]        e3_sy;

  logic signed [33:0] d0;
  logic signed [33:0] d1;
  logic signed [51:0] e4_p0;
  logic signed [51:0] e4_p1;
  logic signed [32:0] e4_z00;
  logic signed [32:0] e4_z10;
  logic [16:0]        e4_sy;

  logic signed [33:0] e5_a;
  logic signed [33:0] e5_b;
  logic [16:0]        e5_sy;

  logic signed [34:0] dn;
  logic signed [52:0] e6_pn;
  logic signed [33:0] e6_a;

  logic signed [34:0] e7_n;
  logic signed [51:0] e8_prod;
  logic [26:0]        q27;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign divisor  = (cell_size == 8'd0) ? 8'd1 : cell_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size <= 8'd1;
      gain      <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CELL_SIZE: cell_size <= cfg_data[7:0];
        REG_GAIN:      gain      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item carrier up to the store access stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NORM_LAT; k++) begin
        dl_valid[k] <= 1'b0;
      end
    end else if (en) begin
      dl_valid[0] <= s_tvalid;
      for (int k = 1; k < NORM_LAT; k++) begin
        dl_valid[k] <= dl_valid[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl_op[0]  <= s_tuser[0];
      dl_row[0] <= s_tdata[7:0];
      dl_col[0] <= s_tdata[15:8];
      for (int k = 1; k < NORM_LAT; k++) begin
        dl_op[k]  <= dl_op[k-1];
        dl_row[k] <= dl_row[k-1];
        dl_col[k] <= dl_col[k-1];
      end
    end
  end

  gn2d_norm u_norm (
    .clk    (clk),
    .en     (en),
    .grad_x (s_tdata[31:16]),
    .grad_y (s_tdata[47:32]),
    .entry  (norm_entry)
  );

  gn2d_celldiv u_div_row (
    .clk     (clk),
    .en      (en),
    .coord   (dl_row[PAD]),
    .divisor (divisor),
    .quot    (y0),
    .frac    (fy)
  );

  gn2d_celldiv u_div_col (
    .clk     (clk),
    .en      (en),
    .coord   (dl_col[PAD]),
    .divisor (divisor),
    .quot    (x0),
    .frac    (fx)
  );

  assign w_valid  = dl_valid[NORM_LAT-1];
  assign w_op     = dl_op[NORM_LAT-1];
  assign w_row    = dl_row[NORM_LAT-1];
  assign w_col    = dl_col[NORM_LAT-1];
  assign load_err = ({1'b0, w_row} >= 9'(GRID_ROWS)) || ({1'b0, w_col} >= 9'(GRID_COLS));
  assign eval_err = ({1'b0, y0} + 9'd1 >= 9'(GRID_ROWS)) ||
                    ({1'b0, x0} + 9'd1 >= 9'(GRID_COLS));

  always_comb begin
    if (w_op == OP_LOAD) begin
      w_status = load_err ? ST_LOAD_RANGE : ST_OK;
    end else begin
      w_status = eval_err ? ST_EVAL_RANGE : ST_OK;
    end
  end

  assign waddr = bank_addr(w_row, w_col);

  // Bank {pr, pc} holds the entries whose row parity is pr and column parity is pc,
  // so the four corners of any cell fall into four different banks.
  always_comb begin
    logic [7:0] rr;
    logic [7:0] cc;
    for (int b = 0; b < 4; b++) begin
      rr         = (y0[0] == b[1]) ? y0 : 8'(y0 + 8'd1);
      cc         = (x0[0] == b[0]) ? x0 : 8'(x0 + 8'd1);
      raddr[b]   = bank_addr(rr, cc);
      bank_we[b] = en && w_valid && (w_op == OP_LOAD) && !load_err &&
                   ({w_row[0], w_col[0]} == 2'(b));
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [ENTRY_W-1:0] mem [BANK_DEPTH];
    always_ff @(posedge clk) begin
      if (en) begin
        if (bank_we[b]) begin
          mem[waddr] <= norm_entry;
        end
        rd[b] <= mem[raddr[b]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 8; k++) begin
        meta[k].valid <= 1'b0;
      end
    end else if (en) begin
      meta[0].valid  <= w_valid;
      meta[0].status <= w_status;
      meta[0].zero   <= (w_op == OP_LOAD) || eval_err;
      for (int k = 1; k < 8; k++) begin
        meta[k] <= meta[k-1];
      end
    end
  end

  // Each bank is dotted with the offsets of the corner that it holds for this cell.
  always_comb begin
    logic signed [14:0] gx;
    logic signed [14:0] gy;
    logic signed [16:0] dxv;
    logic signed [16:0] dyv;
    for (int b = 0; b < 4; b++) begin
      gx          = $signed(rd[b][GRAD_W-1:0]);
      gy          = $signed(rd[b][ENTRY_W-1:GRAD_W]);
      dxv         = $signed({b[0] ^ e1_px, e1_fx});
      dyv         = $signed({b[1] ^ e1_py, e1_fy});
      pgx_next[b] = gx * dxv;
      pgy_next[b] = gy * dyv;
    end
  end

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      zb[b] = 33'(e2_pgx[b]) + 33'(e2_pgy[b]);
    end
    tx = 50'(e2_f2x) * 50'd196608 - 50'({e2_f3x, 1'b0});
    ty = 50'(e2_f2y) * 50'd196608 - 50'({e2_f3y, 1'b0});
  end

  assign d0 = 34'(e3_z01) - 34'(e3_z00);
  assign d1 = 34'(e3_z11) - 34'(e3_z10);
  assign dn = 35'(e5_b) - 35'(e5_a);

  always_ff @(posedge clk) begin
    if (en) begin
      e1_fx  <= fx;
      e1_fy  <= fy;
      e1_px  <= x0[0];
      e1_py  <= y0[0];
      e1_f2x <= 32'(fx) * 32'(fx);
      e1_f2y <= 32'(fy) * 32'(fy);

      for (int b = 0; b < 4; b++) begin
        e2_pgx[b] <= pgx_next[b];
        e2_pgy[b] <= pgy_next[b];
      end
      e2_px  <= e1_px;
      e2_py  <= e1_py;
      e2_f2x <= e1_f2x;
      e2_f2y <= e1_f2y;
      e2_f3x <= 48'(e1_f2x) * 48'(e1_fx);
      e2_f3y <= 48'(e1_f2y) * 48'(e1_fy);

      e3_z00 <= e2_py ? (e2_px ? zb[3] : zb[2]) : (e2_px ? zb[1] : zb[0]);
      e3_z01 <= e2_py ? (e2_px ? zb[2] : zb[3]) : (e2_px ? zb[0] : zb[1]);
      e3_z10 <= e2_py ? (e2_px ? zb[1] : zb[0]) : (e2_px ? zb[3] : zb[2]);
      e3_z11 <= e2_py ? (e2_px ? zb[0] : zb[1]) : (e2_px ? zb[2] : zb[3]);
      e3_sx  <= tx[48:32];
      e3_sy  <= ty[48:32];

      e4_p0  <= $signed({1'b0, e3_sx}) * d0;
      e4_p1  <= $signed({1'b0, e3_sx}) * d1;
      e4_z00 <= e3_z00;
      e4_z10 <= e3_z10;
      e4_sy  <= e3_sy;

      e5_a  <= 34'(e4_z00) + 34'(e4_p0 >>> 16);
      e5_b  <= 34'(e4_z10) + 34'(e4_p1 >>> 16);
      e5_sy <= e4_sy;

      e6_pn <= $signed({1'b0, e5_sy}) * dn;
      e6_a  <= e5_a;

      e7_n <= 35'(e6_a) + 35'(e6_pn >>> 16);

      e8_prod <= e7_n * $signed({1'b0, gain});
    end
  end

  assign q27 = e8_prod[51:25];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= meta[7].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= meta[7].status;
      if (meta[7].zero) begin
        m_tdata <= '0;
      end else if ((&q27[26:23]) || !(|q27[26:23])) begin
        m_tdata <= q27[23:0];
      end else begin
        m_tdata <= q27[26] ? 24'h800000 : 24'h7FFFFF;
      end
    end
  end

  a_single_bank_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0(bank_we))
    else $error("more than one lattice bank written in one cycle");

  a_write_only_good_load: assert property (@(posedge clk) disable iff (rst)
    (bank_we != 4'd0) |-> (w_valid && w_op == OP_LOAD && w_status == ST_OK))
    else $error("lattice store written by an item that is not an in-range load");

  a_error_gives_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
    else $error("error result carries a non-zero noise value");

endmodule
